/* design/fwsp_pkg.sv */
// ----------------------------------------------------------------------------
// fwsp_pkg
// Types and constants of the four wheel speed PID controller.
// ----------------------------------------------------------------------------
package fwsp_pkg;

   localparam int NUM_WHEELS     = 4;
   localparam int COUNT_WIDTH    = 10;
   localparam int DUTY_WIDTH     = 12;
   localparam int GAIN_WIDTH     = 8;
   localparam int INTEG_WIDTH    = 32;
   localparam int CSR_DATA_WIDTH = 12;
   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_TARGET_COUNT = 3'd0,
      CSR_GAIN_P       = 3'd1,
      CSR_GAIN_I       = 3'd2,
      CSR_GAIN_D       = 3'd3,
      CSR_START_DUTY   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                   restart;
      logic [COUNT_WIDTH-1:0] count_wheel_a;
      logic [COUNT_WIDTH-1:0] count_wheel_b;
      logic [COUNT_WIDTH-1:0] count_wheel_c;
      logic [COUNT_WIDTH-1:0] count_wheel_d;
   } req_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0] duty_wheel_a;
      logic [DUTY_WIDTH-1:0] duty_wheel_b;
      logic [DUTY_WIDTH-1:0] duty_wheel_c;
      logic [DUTY_WIDTH-1:0] duty_wheel_d;
   } rsp_type;

endpackage

/* design/four_wheel_speed_pid_top.sv */
// ----------------------------------------------------------------------------
// four_wheel_speed_pid_top
// Incremental PID speed controller, four wheel lanes, PWM duty out.
// ----------------------------------------------------------------------------
//   channel | signals                             | role
//   --------+-------------------------------------+---------------------------
//   req     | req_valid, req_ready, req_data      | one control tick in
//   rsp     | rsp_valid, rsp_ready, rsp_data      | four new duties out
//   csr     | csr_write_en, csr_index, csr_wdata  | register writes
//
// a tick is taken into an input register, then the lane arithmetic updates
// integral, previous count and duty and loads the result register; one tick
// per cycle sustained while the result side does not stall.
// reset clears configuration, valid flags, integrals, previous counts and duties.
// a stalled result holds the result register; the input register still takes
// one more tick, then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module four_wheel_speed_pid_top
   import fwsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int ERR_W  = COUNT_WIDTH + 1;
   localparam int GAIN_S = GAIN_WIDTH + 1;
   localparam int PROD_W = ERR_W + GAIN_S;
   localparam int SUM_W  = INTEG_WIDTH + 3;
   localparam int DSUM_W = SUM_W + 1;

   // configuration registers
   logic [COUNT_WIDTH-1:0] target_ff;
   logic [GAIN_WIDTH-1:0]  gain_p_ff;
   logic [GAIN_WIDTH-1:0]  gain_i_ff;
   logic [GAIN_WIDTH-1:0]  gain_d_ff;
   logic [DUTY_WIDTH-1:0]  start_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         start_duty_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_COUNT: target_ff     <= csr_wdata[COUNT_WIDTH-1:0];
            CSR_GAIN_P:       gain_p_ff     <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_GAIN_I:       gain_i_ff     <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_GAIN_D:       gain_d_ff     <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_START_DUTY:   start_duty_ff <= csr_wdata[DUTY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register and handshake
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // lane state
   logic signed [INTEG_WIDTH-1:0] integ_ff [NUM_WHEELS];
   logic signed [INTEG_WIDTH-1:0] integ_in [NUM_WHEELS];
   logic        [COUNT_WIDTH-1:0] prev_ff  [NUM_WHEELS];
   logic        [COUNT_WIDTH-1:0] prev_in  [NUM_WHEELS];
   logic        [DUTY_WIDTH-1:0]  duty_ff  [NUM_WHEELS];
   logic        [DUTY_WIDTH-1:0]  duty_in  [NUM_WHEELS];

   logic        [COUNT_WIDTH-1:0] cnt      [NUM_WHEELS];
   logic signed [ERR_W-1:0]       err      [NUM_WHEELS];
   logic signed [ERR_W-1:0]       diff     [NUM_WHEELS];
   logic signed [PROD_W-1:0]      prod_p   [NUM_WHEELS];
   logic signed [PROD_W-1:0]      prod_i   [NUM_WHEELS];
   logic signed [PROD_W-1:0]      prod_d   [NUM_WHEELS];
   logic signed [INTEG_WIDTH:0]   integ_wd [NUM_WHEELS];
   logic signed [INTEG_WIDTH-1:0] integ_st [NUM_WHEELS];
   logic signed [SUM_W-1:0]       term_sum [NUM_WHEELS];
   logic signed [DSUM_W-1:0]      duty_wd  [NUM_WHEELS];
   logic        [DUTY_WIDTH-1:0]  duty_cl  [NUM_WHEELS];
   rsp_type                       rsp_data_in;

   always_comb begin
      cnt[0] = in_data_ff.count_wheel_a;
      cnt[1] = in_data_ff.count_wheel_b;
      cnt[2] = in_data_ff.count_wheel_c;
      cnt[3] = in_data_ff.count_wheel_d;
   end

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         err[w]  = signed'({1'b0, target_ff}) - signed'({1'b0, cnt[w]});
         diff[w] = signed'({1'b0, cnt[w]}) - signed'({1'b0, prev_ff[w]});
         prod_p[w] = PROD_W'(err[w])  * PROD_W'(signed'({1'b0, gain_p_ff}));
         prod_i[w] = PROD_W'(err[w])  * PROD_W'(signed'({1'b0, gain_i_ff}));
         prod_d[w] = PROD_W'(diff[w]) * PROD_W'(signed'({1'b0, gain_d_ff}));

         // saturating integral at the signed limits
         integ_wd[w] = (INTEG_WIDTH+1)'(integ_ff[w]) + (INTEG_WIDTH+1)'(prod_i[w]);
         if (integ_wd[w][INTEG_WIDTH] != integ_wd[w][INTEG_WIDTH-1]) begin
            integ_st[w] = {integ_wd[w][INTEG_WIDTH], {(INTEG_WIDTH-1){!integ_wd[w][INTEG_WIDTH]}}};
         end else begin
            integ_st[w] = integ_wd[w][INTEG_WIDTH-1:0];
         end

         term_sum[w] = SUM_W'(prod_p[w]) + SUM_W'(integ_st[w]) + SUM_W'(prod_d[w]);
         duty_wd[w]  = signed'(DSUM_W'({1'b0, duty_ff[w]})) + DSUM_W'(term_sum[w]);

         // clamp into the duty range
         if (duty_wd[w][DSUM_W-1]) begin
            duty_cl[w] = '0;
         end else if (duty_wd[w][DSUM_W-2:DUTY_WIDTH] != '0) begin
            duty_cl[w] = '1;
         end else begin
            duty_cl[w] = duty_wd[w][DUTY_WIDTH-1:0];
         end

         if (in_data_ff.restart) begin
            integ_in[w] = integ_ff[w];
            prev_in[w]  = '0;
            duty_in[w]  = start_duty_ff;
         end else begin
            integ_in[w] = integ_st[w];
            prev_in[w]  = cnt[w];
            duty_in[w]  = duty_cl[w];
         end
      end
   end

   always_comb begin
      rsp_data_in.duty_wheel_a = duty_in[0];
      rsp_data_in.duty_wheel_b = duty_in[1];
      rsp_data_in.duty_wheel_c = duty_in[2];
      rsp_data_in.duty_wheel_d = duty_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WHEELS; w++) begin
            integ_ff[w] <= '0;
            prev_ff[w]  <= '0;
            duty_ff[w]  <= '0;
         end
      end else if (advance) begin
         for (int w = 0; w < NUM_WHEELS; w++) begin
            integ_ff[w] <= integ_in[w];
            prev_ff[w]  <= prev_in[w];
            duty_ff[w]  <= duty_in[w];
         end
      end
   end

   // result register, the output side of a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* tb/sv/four_wheel_speed_pid_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_speed_pid_checker
// Watches the tick, result and register ports of the wheel speed controller.
// Keeps its own copy of gains, integrals, previous counts and duties, works
// out the four duties of every accepted tick and compares each result
// transfer with the oldest duties still owed.
// ----------------------------------------------------------------------------
module four_wheel_speed_pid_checker
   import fwsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output int                        failures,
   output int                        pending
);

   localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_WIDTH - 1)) - 1;
   localparam longint INTEG_MIN = -(longint'(1) <<< (INTEG_WIDTH - 1));
   localparam longint DUTY_MAX  = (longint'(1) << DUTY_WIDTH) - 1;

   logic [COUNT_WIDTH-1:0]        cfg_target;
   logic [GAIN_WIDTH-1:0]         cfg_kp;
   logic [GAIN_WIDTH-1:0]         cfg_ki;
   logic [GAIN_WIDTH-1:0]         cfg_kd;
   logic [DUTY_WIDTH-1:0]         cfg_start_duty;

   logic signed [INTEG_WIDTH-1:0] integ_acc  [NUM_WHEELS];
   logic [COUNT_WIDTH-1:0]        last_count [NUM_WHEELS];
   logic [DUTY_WIDTH-1:0]         duty_now   [NUM_WHEELS];

   rsp_type                       owed_duties [$];

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      failures++;
   endtask

   // lane a sits in the top slice of both payloads, lane d in the bottom one
   task automatic advance_lanes(input req_type tick, output rsp_type duties);
      longint cnt, tgt, err, acc, prev, total;
      tgt = longint'(cfg_target);
      for (int w = 0; w < NUM_WHEELS; w++) begin
         if (tick.restart) begin
            duty_now[w]   = cfg_start_duty;
            last_count[w] = '0;
         end else begin
            cnt  = longint'(tick[(NUM_WHEELS-1-w)*COUNT_WIDTH +: COUNT_WIDTH]);
            prev = longint'(last_count[w]);
            acc  = longint'(integ_acc[w]);
            err  = tgt - cnt;
            acc  = clamp_range(acc + err * longint'(cfg_ki), INTEG_MIN, INTEG_MAX);
            integ_acc[w] = acc[INTEG_WIDTH-1:0];
            total = err * longint'(cfg_kp) + acc + (cnt - prev) * longint'(cfg_kd);
            duty_now[w]   = DUTY_WIDTH'(clamp_range(longint'(duty_now[w]) + total,
                                                    0, DUTY_MAX));
            last_count[w] = cnt[COUNT_WIDTH-1:0];
         end
         duties[(NUM_WHEELS-1-w)*DUTY_WIDTH +: DUTY_WIDTH] = duty_now[w];
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type               want;
      logic [DUTY_WIDTH-1:0] got_lane;
      logic [DUTY_WIDTH-1:0] want_lane;
      if (reset) begin
         cfg_target     = '0;
         cfg_kp         = '0;
         cfg_ki         = '0;
         cfg_kd         = '0;
         cfg_start_duty = '0;
         for (int w = 0; w < NUM_WHEELS; w++) begin
            integ_acc[w]  = '0;
            last_count[w] = '0;
            duty_now[w]   = '0;
         end
         owed_duties.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TARGET_COUNT: cfg_target     = csr_wdata[COUNT_WIDTH-1:0];
               CSR_GAIN_P:       cfg_kp         = csr_wdata[GAIN_WIDTH-1:0];
               CSR_GAIN_I:       cfg_ki         = csr_wdata[GAIN_WIDTH-1:0];
               CSR_GAIN_D:       cfg_kd         = csr_wdata[GAIN_WIDTH-1:0];
               CSR_START_DUTY:   cfg_start_duty = csr_wdata[DUTY_WIDTH-1:0];
               default: ;
            endcase
         end
         // a result never leaves in the same cycle its tick is taken, so pop before push
         if (rsp_valid && rsp_ready) begin
            if (owed_duties.size() == 0) begin
               flag_mismatch($sformatf("result %h with no tick outstanding", rsp_data));
            end else begin
               want = owed_duties.pop_front();
               for (int w = 0; w < NUM_WHEELS; w++) begin
                  got_lane  = rsp_data[(NUM_WHEELS-1-w)*DUTY_WIDTH +: DUTY_WIDTH];
                  want_lane = want[(NUM_WHEELS-1-w)*DUTY_WIDTH +: DUTY_WIDTH];
                  if (got_lane !== want_lane) begin
                     flag_mismatch($sformatf("duty_wheel_%c: got %0d, expected %0d",
                                             8'd97 + w[7:0], got_lane, want_lane));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_lanes(req_data, want);
            owed_duties.push_back(want);
         end
      end
      pending <= owed_duties.size();
   end

endmodule

/* tb/sv/four_wheel_speed_pid_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_speed_pid_top_tb
// Drives control ticks and register writes into the wheel speed controller:
// a directed start on the field extremes and restarts, then randomized phases
// of gains and targets with ticks around the target, every third one and the
// last two with no idling on either side. The checker does all compares.
// ----------------------------------------------------------------------------
module four_wheel_speed_pid_top_tb;
   import fwsp_pkg::*;

   localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
   localparam int GAIN_MAX    = (1 << GAIN_WIDTH) - 1;
   localparam int DUTY_MAX    = (1 << DUTY_WIDTH) - 1;
   localparam int PHASES      = 14;
   localparam int PHASE_TICKS = 100;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   req_type                   req_data     = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_en = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_index    = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata    = '0;

   int failures;
   int pending;
   bit idle_on    = 1'b0;
   int stall_left = 0;

   four_wheel_speed_pid_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   four_wheel_speed_pid_checker duty_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .failures     (failures),
      .pending      (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // while idling is on, the result side now and then stalls for a burst
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #(64'd40_000_000);
      $display("four_wheel_speed_pid_top test failed");
      $finish;
   end

   // called at a falling edge, returns at a falling edge after the transfer
   task automatic send_tick(input req_type tick);
      req_data  <= tick;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_counts(input bit restart, input int a, input int b,
                              input int c, input int d);
      req_type tick;
      tick.restart       = restart;
      tick.count_wheel_a = a[COUNT_WIDTH-1:0];
      tick.count_wheel_b = b[COUNT_WIDTH-1:0];
      tick.count_wheel_c = c[COUNT_WIDTH-1:0];
      tick.count_wheel_d = d[COUNT_WIDTH-1:0];
      send_tick(tick);
   endtask

   // hold off the tick side until every owed result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // writes every register, junk above each field, then one unused index
   task automatic set_config(input int target, input int kp, input int ki,
                             input int kd, input int start);
      int value;
      int width;
      int mask;
      int junk;
      drain();
      for (int i = 0; i <= CSR_START_DUTY + 1; i++) begin
         junk = $urandom;
         case (i)
            CSR_TARGET_COUNT: begin value = target; width = COUNT_WIDTH; end
            CSR_GAIN_P:       begin value = kp;     width = GAIN_WIDTH;  end
            CSR_GAIN_I:       begin value = ki;     width = GAIN_WIDTH;  end
            CSR_GAIN_D:       begin value = kd;     width = GAIN_WIDTH;  end
            CSR_START_DUTY:   begin value = start;  width = DUTY_WIDTH;  end
            default:          begin value = junk;   width = 0;           end
         endcase
         mask = (1 << width) - 1;
         csr_write_en <= 1'b1;
         if (i > CSR_START_DUTY)
            csr_index <= CSR_ADDR_WIDTH'(CSR_START_DUTY + 1 +
                         $urandom_range(0, (1 << CSR_ADDR_WIDTH) - 2 - CSR_START_DUTY));
         else
            csr_index <= i[CSR_ADDR_WIDTH-1:0];
         csr_wdata <= CSR_DATA_WIDTH'((value & mask) | (junk & ~mask));
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic int pick_gain();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return GAIN_MAX;
         2:       return $urandom_range(0, GAIN_MAX);
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   function automatic int pick_edge_or_any(input int top);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   function automatic int near_count(input int center);
      int v;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, COUNT_MAX);
      v = center + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > COUNT_MAX) v = COUNT_MAX;
      return v;
   endfunction

   initial begin
      int tgt;
      repeat (2) @(negedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // all registers still zero after reset
      send_counts(0, 0, 0, 0, 0);
      send_counts(0, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);

      // largest gains: restart ignores its counts, then both clamps of the duty
      set_config(COUNT_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, DUTY_MAX);
      send_counts(1, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);
      send_counts(0, 0, 0, 0, 0);
      send_counts(0, COUNT_MAX, 0, 'h155, 'h2AA);
      send_counts(0, 'h2AA, 'h155, COUNT_MAX, 0);
      set_config(0, GAIN_MAX, 0, GAIN_MAX, 0);
      send_counts(0, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);
      send_counts(1, 'h155, 'h2AA, 'h155, 'h2AA);
      send_counts(0, 0, 0, 0, 0);

      // unit gains around mid target
      set_config(512, 1, 1, 1, 2048);
      send_counts(1, 0, 0, 0, 0);
      send_counts(0, 512, 511, 513, 500);
      send_counts(0, 520, 505, 512, 0);
      send_counts(0, 512, 512, 512, 512);
      send_counts(1, COUNT_MAX, 0, COUNT_MAX, 0);
      send_counts(0, 400, 600, 512, 700);

      // every third phase and the last two run with no idling on either side
      for (int phase = 0; phase < PHASES; phase++) begin
         tgt = pick_edge_or_any(COUNT_MAX);
         set_config(tgt, pick_gain(), pick_gain(), pick_gain(),
                    pick_edge_or_any(DUTY_MAX));
         idle_on = (phase % 3 != 2) && (phase < PHASES - 2);
         repeat (PHASE_TICKS) begin
            if ($urandom_range(0, 49) == 0) drain();
            send_counts($urandom_range(0, 11) == 0, near_count(tgt), near_count(tgt),
                        near_count(tgt), near_count(tgt));
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("four_wheel_speed_pid_top test passed");
      end else begin
         $display("four_wheel_speed_pid_top test failed");
      end
      $finish;
   end

endmodule
